@@ rtl/ddo_pkg.sv @@
// Package for the differential drive odometry block.
// Register indexes, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int K_ANGLE_BITS   = 16;
    localparam int K_CORDIC_STEPS = 16;
    localparam int K_ATAN_DEPTH   = 24;
    localparam int K_IDX_W        = 5;

    localparam logic [1:0] REG_LEFT_MM  = 2'd0;
    localparam logic [1:0] REG_RIGHT_MM = 2'd1;
    localparam logic [1:0] REG_TURN     = 2'd2;

    localparam logic [31:0] K_MM_RESET   = 32'd65536;
    localparam logic [23:0] K_TURN_RESET = 24'd65536;

    localparam logic signed [33:0] K_GAIN       = 34'sd652032874;
    localparam logic signed [63:0] K_TRAVEL_MAX = 64'sd140737488355327;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_lut(input logic [K_IDX_W-1:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

    // Q4.30 to Q2.16, round half up, clamp to one
    function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [34:0] r;
        begin
            t = {v[33], v} + 35'sd8192;
            r = t >>> 14;
            if (r > 35'sd65536) begin
                r = 35'sd65536;
            end else if (r < -35'sd65536) begin
                r = -35'sd65536;
            end
            return r[17:0];
        end
    endfunction

endpackage

@@ rtl/differential_drive_odometry.sv @@
// Differential drive odometry: top level, single module.
// Depends on ddo_pkg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready    | left/right count, use_compass, compass
//  output   | o_out_valid / i_out_ready  | pos x/y, heading, left/right delta
//  config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// Each request runs through the sequencer states in order, using the shared 33x33
// multiplier eight times and running the CORDIC loop at one step per cycle.
// Ready is high only while idle. A finished result waits in the output register;
// the next request may be taken meanwhile, and its result waits for that slot.
// Synchronous reset clears state, last counts, pose and valid; registers to defaults.
`timescale 1ns / 1ps

module differential_drive_odometry #(
    parameter int ANGLE_BITS   = ddo_pkg::K_ANGLE_BITS,
    parameter int CORDIC_STEPS = ddo_pkg::K_CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [31:0]         i_left_count,
    input  logic [31:0]         i_right_count,
    input  logic                i_use_compass,
    input  logic signed [15:0]  i_compass_angle,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [47:0]  o_pos_x,
    output logic signed [47:0]  o_pos_y,
    output logic signed [15:0]  o_heading_angle,
    output logic signed [31:0]  o_left_delta,
    output logic signed [31:0]  o_right_delta
);

    localparam logic [31:0] ZMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam logic [ddo_pkg::K_IDX_W-1:0] LAST_STEP = ddo_pkg::K_IDX_W'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MULL, S_MULR, S_DIFF, S_TLO, S_THI, S_HEAD, S_CINIT,
        S_CORD, S_CFIN, S_MXL, S_MXH, S_XADD, S_MYH, S_YADD, S_DONE
    } t_state;

    t_state r_state;

    logic [31:0]        r_left_mm, r_right_mm;
    logic [23:0]        r_turn;
    logic [31:0]        r_last_l, r_last_r;
    logic [31:0]        r_ld, r_rd;
    logic               r_use_c;
    logic [15:0]        r_compass;
    logic [15:0]        r_head;
    logic [47:0]        r_px, r_py;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_wl;
    logic [55:0]        r_d;
    logic [55:0]        r_acc;
    logic [63:0]        r_acc64;
    logic signed [47:0] r_travel;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_flip;
    logic [ddo_pkg::K_IDX_W-1:0] r_cnt;
    logic signed [17:0] r_sin, r_cos;

    logic               r_out_valid;
    logic signed [47:0] r_o_x, r_o_y;
    logic [15:0]        r_o_head;
    logic [31:0]        r_o_ld, r_o_rd;

    logic signed [32:0] m_a, m_b;
    logic signed [65:0] w_prod;
    logic signed [64:0] w_sum;
    logic signed [63:0] w_trav;
    logic [55:0]        w_turn;
    logic [31:0]        w_z32;
    logic [33:0]        w_atan;
    logic signed [33:0] w_xs, w_ys;
    logic [63:0]        w_step;

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_MULL: begin
                m_a = $signed({r_ld[31], r_ld});
                m_b = $signed({1'b0, r_left_mm});
            end
            S_MULR: begin
                m_a = $signed({r_rd[31], r_rd});
                m_b = $signed({1'b0, r_right_mm});
            end
            S_TLO: begin
                m_a = $signed({5'd0, r_d[27:0]});
                m_b = $signed({9'd0, r_turn});
            end
            S_THI: begin
                m_a = $signed({5'd0, r_d[55:28]});
                m_b = $signed({9'd0, r_turn});
            end
            S_MXL: begin
                m_a = $signed({9'd0, r_travel[23:0]});
                m_b = 33'(r_sin);
            end
            S_MXH: begin
                m_a = 33'($signed(r_travel[47:24]));
                m_b = 33'(r_sin);
            end
            S_XADD: begin
                m_a = $signed({9'd0, r_travel[23:0]});
                m_b = 33'(r_cos);
            end
            S_MYH: begin
                m_a = 33'($signed(r_travel[47:24]));
                m_b = 33'(r_cos);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign w_prod = m_a * m_b;
    assign w_sum  = {r_wl[63], r_wl} + {r_prod[63], r_prod};
    assign w_trav = w_sum[64:1];
    assign w_turn = r_acc + {r_prod[27:0], 28'd0};
    assign w_z32  = {r_head, 16'd0} & ZMASK;
    assign w_atan = {2'b00, ddo_pkg::atan_lut(r_cnt) & ZMASK};
    assign w_xs   = r_cx >>> r_cnt;
    assign w_ys   = r_cy >>> r_cnt;
    assign w_step = {r_prod[39:0], 24'd0} + r_acc64 + 64'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left_mm   <= ddo_pkg::K_MM_RESET;
            r_right_mm  <= ddo_pkg::K_MM_RESET;
            r_turn      <= ddo_pkg::K_TURN_RESET;
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_head      <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ddo_pkg::REG_LEFT_MM:  r_left_mm  <= i_cfg_data;
                    ddo_pkg::REG_RIGHT_MM: r_right_mm <= i_cfg_data;
                    ddo_pkg::REG_TURN:     r_turn     <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_prod <= w_prod[63:0];
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ld      <= i_left_count - r_last_l;
                        r_rd      <= i_right_count - r_last_r;
                        r_last_l  <= i_left_count;
                        r_last_r  <= i_right_count;
                        r_use_c   <= i_use_compass;
                        r_compass <= i_compass_angle;
                        r_state   <= S_MULL;
                    end
                end
                S_MULL: r_state <= S_MULR;
                S_MULR: begin
                    r_wl    <= r_prod;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_d <= r_wl[55:0] - r_prod[55:0];
                    if (w_trav > ddo_pkg::K_TRAVEL_MAX) begin
                        r_travel <= ddo_pkg::K_TRAVEL_MAX[47:0];
                    end else if (w_trav < -ddo_pkg::K_TRAVEL_MAX) begin
                        r_travel <= -(ddo_pkg::K_TRAVEL_MAX[47:0]);
                    end else begin
                        r_travel <= w_trav[47:0];
                    end
                    r_state <= S_TLO;
                end
                S_TLO: r_state <= S_THI;
                S_THI: begin
                    r_acc   <= r_prod[55:0] + (56'd1 << 39);
                    r_state <= S_HEAD;
                end
                S_HEAD: begin
                    r_head  <= r_use_c ? r_compass : r_head + w_turn[55:40];
                    r_state <= S_CINIT;
                end
                S_CINIT: begin
                    // fold the left half plane onto the right half plane
                    r_flip  <= w_z32[31] ^ w_z32[30];
                    r_cz    <= 34'($signed({w_z32[31] ^ (w_z32[31] ^ w_z32[30]), w_z32[30:0]}));
                    r_cx    <= ddo_pkg::K_GAIN;
                    r_cy    <= '0;
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - $signed(w_atan);
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + $signed(w_atan);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_CFIN;
                    end
                end
                S_CFIN: begin
                    r_sin   <= r_flip ? -ddo_pkg::to_q16(r_cy) : ddo_pkg::to_q16(r_cy);
                    r_cos   <= r_flip ? -ddo_pkg::to_q16(r_cx) : ddo_pkg::to_q16(r_cx);
                    r_state <= S_MXL;
                end
                S_MXL: r_state <= S_MXH;
                S_MXH: begin
                    r_acc64 <= r_prod;
                    r_state <= S_XADD;
                end
                S_XADD: begin
                    r_px    <= r_px + w_step[63:16];
                    r_state <= S_MYH;
                end
                S_MYH: begin
                    r_acc64 <= r_prod;
                    r_state <= S_YADD;
                end
                S_YADD: begin
                    r_py    <= r_py + w_step[63:16];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_x       <= r_px;
                        r_o_y       <= r_py;
                        r_o_head    <= r_head;
                        r_o_ld      <= r_ld;
                        r_o_rd      <= r_rd;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_o_x;
    assign o_pos_y         = r_o_y;
    assign o_heading_angle = r_o_head;
    assign o_left_delta    = r_o_ld;
    assign o_right_delta   = r_o_rd;

endmodule

@@ rtl/ddo_checker.sv @@
// Port-level checks for the differential drive odometry block.
// Bound to differential_drive_odometry; uses no package items.
`timescale 1ns / 1ps

module ddo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [47:0] o_pos_x
);

    // a request is never taken twice in a row: the sequencer is busy after it
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready high right after a request");

    // a result never appears in the cycle after a request
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result one cycle after request");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pos_x)))
        else $error("stalled result dropped or changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("reset did not clear");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pos_x     (o_pos_x)
);

@@ dv/tb_top.sv @@
// Testbench for differential_drive_odometry: directed table then random encoder samples,
// each result checked against an in-bench dead-reckoning predictor with CORDIC sin/cos.
// Depends on ddo_pkg and rtl/differential_drive_odometry.sv.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [31:0] lc;
        logic [31:0] rc;
        logic        uc;
        logic [15:0] ca;
    } t_sample;

    typedef struct packed {
        logic [47:0] px;
        logic [47:0] py;
        logic [15:0] hd;
        logic [31:0] ld;
        logic [31:0] rd;
    } t_pose;

    typedef struct {
        t_sample s;
        logic    has_pose;
        t_pose   p;
    } t_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic [31:0] i_left_count = '0;
    logic [31:0] i_right_count = '0;
    logic i_use_compass = 0;
    logic signed [15:0] i_compass_angle = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic signed [47:0] o_pos_x, o_pos_y;
    logic signed [15:0] o_heading_angle;
    logic signed [31:0] o_left_delta, o_right_delta;

    differential_drive_odometry u_top (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] mm_l = ddo_pkg::K_MM_RESET, mm_r = ddo_pkg::K_MM_RESET;
    logic [23:0] turn_k = ddo_pkg::K_TURN_RESET;
    logic [31:0] prev_l = 0, prev_r = 0;
    logic [15:0] hdg = 0;
    logic [47:0] xpos = 0, ypos = 0;
    t_pose pose_q[$];
    t_pose last_pose;
    t_row directed[$];
    int errors = 0;
    bit hold_long = 0;

    function automatic longint q16_round(longint v);
        longint r;
        r = (v + 8192) >>> 14;
        if (r > 65536) r = 65536;
        if (r < -65536) r = -65536;
        return r;
    endfunction

    function automatic void cordic_sincos(logic [15:0] h, output longint s, output longint c);
        logic [31:0] zmask, z32, a;
        longint x, y, z, nx;
        bit flip;
        zmask = ~((32'd1 << (32 - ddo_pkg::K_ANGLE_BITS)) - 1);
        z32 = {h, 16'd0} & zmask;
        flip = (z32[31:30] == 2'b01) || (z32[31:30] == 2'b10);
        if (flip) z32 ^= 32'h80000000;
        z = longint'($signed(z32));
        x = 652032874;
        y = 0;
        for (int i = 0; i < ddo_pkg::K_CORDIC_STEPS && i < 24; i++) begin
            a = ddo_pkg::atan_lut(i[4:0]) & zmask;
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(a);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += longint'(a);
            end
            x = nx;
        end
        s = q16_round(y);
        c = q16_round(x);
        if (flip) begin
            s = -s; c = -c;
        end
    endfunction

    function automatic t_pose advance_pose(t_sample smp);
        t_pose p;
        logic [31:0] dl, dr;
        longint wl, wr, trav, s, c;
        logic [63:0] prod;
        dl = smp.lc - prev_l;
        dr = smp.rc - prev_r;
        wl = longint'($signed(dl)) * longint'({32'd0, mm_l});
        wr = longint'($signed(dr)) * longint'({32'd0, mm_r});
        trav = (wl >>> 1) + (wr >>> 1) + longint'(wl[0] & wr[0]);
        if (trav > ddo_pkg::K_TRAVEL_MAX) trav = ddo_pkg::K_TRAVEL_MAX;
        if (trav < -ddo_pkg::K_TRAVEL_MAX) trav = -ddo_pkg::K_TRAVEL_MAX;
        if (smp.uc) hdg = smp.ca;
        else begin
            prod = (64'(wl) - 64'(wr)) * {40'd0, turn_k} + (64'd1 << 39);
            hdg = hdg + prod[55:40];
        end
        cordic_sincos(hdg, s, c);
        xpos = xpos + 48'((trav * s + 32768) >>> 16);
        ypos = ypos + 48'((trav * c + 32768) >>> 16);
        prev_l = smp.lc;
        prev_r = smp.rc;
        p.px = xpos; p.py = ypos; p.hd = hdg; p.ld = dl; p.rd = dr;
        return p;
    endfunction

    task automatic send_sample(t_sample smp);
        i_in_valid <= 1;
        i_left_count <= smp.lc;
        i_right_count <= smp.rc;
        i_use_compass <= smp.uc;
        i_compass_angle <= smp.ca;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        last_pose = advance_pose(smp);
        pose_q.push_back(last_pose);
        @(negedge i_clk);
        i_in_valid <= 0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        while (pose_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            ddo_pkg::REG_LEFT_MM:  mm_l = val;
            ddo_pkg::REG_RIGHT_MM: mm_r = val;
            ddo_pkg::REG_TURN:     turn_k = val[23:0];
            default: ;
        endcase
    endtask

    function automatic t_sample rand_sample(int mode);
        t_sample s;
        s.uc = ($urandom_range(0, 5) == 0);
        s.ca = 16'($urandom);
        if (mode == 0) begin
            s.lc = prev_l + 32'($signed($urandom_range(0, 400)) - 200);
            s.rc = prev_r + 32'($signed($urandom_range(0, 400)) - 200);
        end else begin
            s.lc = $urandom; s.rc = $urandom;
        end
        return s;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected result", $time);
                errors++;
            end else begin
                e = pose_q.pop_front();
                if (o_pos_x !== e.px)
                    $display("%0t: pos_x exp %h got %h", $time, e.px, o_pos_x);
                if (o_pos_y !== e.py)
                    $display("%0t: pos_y exp %h got %h", $time, e.py, o_pos_y);
                if (o_heading_angle !== e.hd)
                    $display("%0t: heading exp %h got %h", $time, e.hd, o_heading_angle);
                if (o_left_delta !== e.ld)
                    $display("%0t: left_delta exp %h got %h", $time, e.ld, o_left_delta);
                if (o_right_delta !== e.rd)
                    $display("%0t: right_delta exp %h got %h", $time, e.rd, o_right_delta);
                if ({o_pos_x, o_pos_y, o_heading_angle, o_left_delta, o_right_delta} !== e)
                    errors++;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (hold_long) i_out_ready <= 0;
        else if ($urandom_range(0, 19) == 0) i_out_ready <= 0;
        else i_out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_row r;
        // after reset: zero move keeps origin
        r.s = '{32'd0, 32'd0, 1'b0, 16'd0}; r.has_pose = 1;
        r.p = '{48'd0, 48'd0, 16'd0, 32'd0, 32'd0}; directed.push_back(r);
        r.has_pose = 0;
        r.s = '{32'd100, 32'd100, 1'b0, 16'd0}; directed.push_back(r);
        r.s = '{32'd200, 32'd150, 1'b0, 16'h7fff}; directed.push_back(r);
        r.s = '{32'd150, 32'd200, 1'b1, 16'h4000}; directed.push_back(r);
        r.s = '{32'd250, 32'd300, 1'b1, 16'h8000}; directed.push_back(r);
        r.s = '{32'd350, 32'd400, 1'b1, 16'hc000}; directed.push_back(r);
        r.s = '{32'd360, 32'd400, 1'b1, 16'h7fff}; directed.push_back(r);
        r.s = '{32'hffffffff, 32'hffffffff, 1'b0, 16'hffff}; directed.push_back(r);
        r.s = '{32'd5, 32'd5, 1'b0, 16'd0}; directed.push_back(r);   // encoder wrap
        r.s = '{32'h80000005, 32'h00000005, 1'b0, 16'd0}; directed.push_back(r);
        r.s = '{32'h00000005, 32'h80000005, 1'b0, 16'd0}; directed.push_back(r);
        r.s = '{32'h7fffffff, 32'h7fffffff, 1'b0, 16'h5555}; directed.push_back(r);
        r.s = '{32'hffffffff, 32'h00000000, 1'b1, 16'haaaa}; directed.push_back(r);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        foreach (directed[k]) begin
            send_sample(directed[k].s);
            if (directed[k].has_pose && last_pose !== directed[k].p) begin
                $display("%0t: directed row %0d exp %h got %h", $time, k,
                         directed[k].p, last_pose);
                errors++;
            end
        end
        // huge travel: saturates
        write_reg(ddo_pkg::REG_LEFT_MM, 32'hffffffff);
        write_reg(ddo_pkg::REG_RIGHT_MM, 32'hffffffff);
        write_reg(ddo_pkg::REG_TURN, 32'h00ffffff);
        send_sample('{32'h7fffffff, 32'h7fffffff, 1'b0, 16'd0});
        send_sample('{32'h00000000, 32'hffffffff, 1'b0, 16'd0});
        send_sample('{32'h80000000, 32'h80000000, 1'b1, 16'h1234});
        write_reg(ddo_pkg::REG_LEFT_MM, 32'd0);
        write_reg(ddo_pkg::REG_RIGHT_MM, 32'd0);
        write_reg(ddo_pkg::REG_TURN, 32'd0);
        send_sample('{32'h12345678, 32'h9abcdef0, 1'b0, 16'd0});

        // long receiver hold while input keeps coming
        fork
            begin
                hold_long = 1;
                repeat (300) @(posedge i_clk);
                hold_long = 0;
            end
            for (int k = 0; k < 4; k++) send_sample(rand_sample(0));
        join

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(ddo_pkg::REG_LEFT_MM, ddo_pkg::K_MM_RESET);
                    write_reg(ddo_pkg::REG_RIGHT_MM, ddo_pkg::K_MM_RESET);
                    write_reg(ddo_pkg::REG_TURN, 32'(ddo_pkg::K_TURN_RESET));
                end
                1: begin
                    write_reg(ddo_pkg::REG_LEFT_MM, 32'h0001_8000);
                    write_reg(ddo_pkg::REG_RIGHT_MM, 32'h0000_c000);
                    write_reg(ddo_pkg::REG_TURN, 32'h00_0400);
                end
                default: begin
                    write_reg(ddo_pkg::REG_LEFT_MM, $urandom);
                    write_reg(ddo_pkg::REG_RIGHT_MM, $urandom);
                    write_reg(ddo_pkg::REG_TURN, $urandom_range(0, 24'hffffff));
                end
            endcase
            for (int k = 0; k < 270; k++)
                send_sample(rand_sample($urandom_range(0, 9) == 0));
        end

        while (pose_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
